/* design/cfd_pkg.sv */
package cfd_pkg;

    // Largest payload a frame may carry on the result side
    localparam int unsigned MAX_PAYLOAD_DEF = 8;
    localparam int unsigned PAYLOAD_SLOTS   = 8;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned LENGTH_W = 4;
    localparam int unsigned COUNT_W  = 4;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [ID_W-1:0]     frame_id_t;
    typedef logic [LENGTH_W-1:0] length_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Field that the next received byte belongs to
    typedef enum logic [1:0] {
        PH_ID_HIGH = 2'd0,
        PH_ID_LOW  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

endpackage

/* design/cfd_channels.sv */
// Byte beat from the host serial stream
interface cfd_byte_if
    import cfd_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Completed frame beat
interface cfd_frame_if
    import cfd_pkg::*;
();
    logic      valid;
    logic      ready;
    frame_id_t frame_id;
    length_t   frame_length;
    byte_t     payload_0;
    byte_t     payload_1;
    byte_t     payload_2;
    byte_t     payload_3;
    byte_t     payload_4;
    byte_t     payload_5;
    byte_t     payload_6;
    byte_t     payload_7;

    modport source (
        output valid, output frame_id, output frame_length,
        output payload_0, output payload_1, output payload_2, output payload_3,
        output payload_4, output payload_5, output payload_6, output payload_7,
        input  ready
    );
    modport sink (
        input  valid, input frame_id, input frame_length,
        input  payload_0, input payload_1, input payload_2, input payload_3,
        input  payload_4, input payload_5, input payload_6, input payload_7,
        output ready
    );
endinterface

/* design/byte_stream_can_frame_deframer_core.sv */
// Channel | Port   | Direction | Beat
// --------+--------+-----------+-----------------------------------------------
// rx      | rx     | sink      | one byte of the host stream
// frames  | frames | source    | identifier, length and eight payload bytes
//
// One byte is taken every cycle while rx is not stalled; the frame field update is one short step
// between the phase/store registers and the result register.
// A frame appears on frames in the cycle after its final byte is taken.
// rx is stalled only while a finished frame waits and frames.ready is low.
// Reset returns the block to waiting for the identifier high byte.
module byte_stream_can_frame_deframer_core
    import cfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input logic        clk,
    input logic        rst_n,
    cfd_byte_if.sink   rx,
    cfd_frame_if.source frames
);

    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam length_t     LIMIT = length_t'(MAX_PAYLOAD);

    phase_t    phase_reg, phase_next;
    frame_id_t id_reg, id_next;
    length_t   length_reg, length_next;
    count_t    count_reg, count_next;
    byte_t     store_reg [MAX_PAYLOAD];

    logic      out_valid_reg;
    frame_id_t out_id_reg;
    length_t   out_length_reg;
    byte_t     out_payload_reg [PAYLOAD_SLOTS];

    logic      rx_beat;
    logic      emit;
    logic      store_wr;
    logic [IDX_W-1:0] store_idx;
    length_t   len_clamped;
    length_t   emit_length;
    byte_t     payload_next [PAYLOAD_SLOTS];

    // Take a byte unless a finished frame is stuck on the output
    assign rx.ready    = !out_valid_reg || frames.ready;
    assign rx_beat     = rx.valid && rx.ready;
    assign store_idx   = count_reg[IDX_W-1:0];
    assign len_clamped = (rx.rx_byte > byte_t'(LIMIT)) ? LIMIT
                                                       : rx.rx_byte[LENGTH_W-1:0];

    // Advance the frame field sequence
    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        store_wr    = 1'b0;
        if (rx_beat)
        begin
            case (phase_reg)
                PH_ID_HIGH:
                begin
                    id_next    = {rx.rx_byte, byte_t'(0)};
                    phase_next = PH_ID_LOW;
                end
                PH_ID_LOW:
                begin
                    id_next    = {id_reg[ID_W-1:BYTE_W], rx.rx_byte};
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    length_next = len_clamped;
                    count_next  = '0;
                    if (len_clamped == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_ID_HIGH;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    store_wr   = 1'b1;
                    count_next = count_reg + count_t'(1);
                    if (count_next >= length_reg)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_ID_HIGH;
                    end
                end
                default:
                begin
                    phase_next = PH_ID_HIGH;
                end
            endcase
        end
    end

    // Build the outgoing payload, zeroing bytes beyond the length
    assign emit_length = length_next;

    for (genvar k = 0; k < PAYLOAD_SLOTS; k++)
    begin : g_slot
        if (k < MAX_PAYLOAD)
        begin : g_used
            always_comb
            begin
                if (length_t'(k) >= emit_length)
                begin
                    payload_next[k] = '0;
                end
                else if (store_wr && (store_idx == IDX_W'(k)))
                begin
                    payload_next[k] = rx.rx_byte;
                end
                else
                begin
                    payload_next[k] = store_reg[k];
                end
            end
        end
        else
        begin : g_unused
            assign payload_next[k] = '0;
        end
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID_HIGH;
            id_reg     <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // Store payload bytes as they arrive
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[store_idx] <= rx.rx_byte;
        end
    end

    // Result register: load on a completed frame, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frames.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg      <= id_next;
            out_length_reg  <= emit_length;
            out_payload_reg <= payload_next;
        end
    end

    assign frames.valid        = out_valid_reg;
    assign frames.frame_id     = out_id_reg;
    assign frames.frame_length = out_length_reg;
    assign frames.payload_0    = out_payload_reg[0];
    assign frames.payload_1    = out_payload_reg[1];
    assign frames.payload_2    = out_payload_reg[2];
    assign frames.payload_3    = out_payload_reg[3];
    assign frames.payload_4    = out_payload_reg[4];
    assign frames.payload_5    = out_payload_reg[5];
    assign frames.payload_6    = out_payload_reg[6];
    assign frames.payload_7    = out_payload_reg[7];

endmodule

/* tb/byte_stream_can_frame_deframer_core_test.sv */
module byte_stream_can_frame_deframer_core_test;
    import cfd_pkg::*;

    localparam int unsigned LEN_CLAMP =
        (MAX_PAYLOAD_DEF > PAYLOAD_SLOTS) ? PAYLOAD_SLOTS : MAX_PAYLOAD_DEF;
    localparam int STREAM_BYTES = 550;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        byte_t value;
        bit    drain_first;
    } stream_beat_t;

    typedef struct {
        frame_id_t id;
        length_t   len;
        byte_t     payload [PAYLOAD_SLOTS];
    } frame_t;

    logic clk;
    logic rst_n;

    cfd_byte_if  rx_ch ();
    cfd_frame_if frame_ch ();

    byte_stream_can_frame_deframer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .frames (frame_ch)
    );

    stream_beat_t byte_backlog [$];
    frame_t       frames_due [$];
    int           frames_owed;
    int           bytes_taken;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           faults;
    int           quiet_cycles;

    // Shadow of the deframer state
    phase_t    shadow_phase;
    frame_id_t shadow_id;
    length_t   shadow_len;
    count_t    shadow_count;
    byte_t     shadow_payload [PAYLOAD_SLOTS];

    // Advance the shadow deframer by one byte; queue a frame when one completes
    task automatic absorb_byte(input byte_t b);
        frame_t rec;
        bit     done;
        done = 1'b0;
        case (shadow_phase)
            PH_ID_HIGH:
            begin
                shadow_id    = {b, 8'h00};
                shadow_phase = PH_ID_LOW;
            end
            PH_ID_LOW:
            begin
                shadow_id[7:0] = b;
                shadow_phase   = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                shadow_len   = (b > LEN_CLAMP) ? length_t'(LEN_CLAMP) : length_t'(b);
                shadow_count = '0;
                if (shadow_len == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    shadow_phase = PH_PAYLOAD;
                end
            end
            default:
            begin
                shadow_payload[shadow_count[2:0]] = b;
                shadow_count = shadow_count + 1'b1;
                if (shadow_count >= shadow_len)
                begin
                    done = 1'b1;
                end
            end
        endcase
        if (done)
        begin
            shadow_phase = PH_ID_HIGH;
            rec.id  = shadow_id;
            rec.len = shadow_len;
            for (int k = 0; k < PAYLOAD_SLOTS; k++)
            begin
                rec.payload[k] = (k < shadow_len) ? shadow_payload[k] : '0;
            end
            frames_due.push_back(rec);
            frames_owed++;
        end
    endtask

    task automatic add_beat(input byte_t v, input bit drain);
        stream_beat_t s;
        s.value       = v;
        s.drain_first = drain;
        byte_backlog.push_back(s);
    endtask

    // Queue a well-formed frame; payload bytes come from the list, then random
    task automatic add_frame(input frame_id_t id, input byte_t len_field,
                             input byte_t fill [$], input bit drain);
        int n;
        n = (len_field > LEN_CLAMP) ? LEN_CLAMP : len_field;
        add_beat(id[15:8], drain);
        add_beat(id[7:0], 1'b0);
        add_beat(len_field, 1'b0);
        for (int k = 0; k < n; k++)
        begin
            add_beat((k < fill.size()) ? fill[k] : byte_t'($urandom), 1'b0);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Byte driver
    always @(posedge clk)
    begin
        bit go;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                absorb_byte(rx_ch.rx_byte);
                void'(byte_backlog.pop_front());
                bytes_taken++;
            end
            if (frame_ch.valid && frame_ch.ready)
            begin
                frames_owed--;
            end

            // Pick the idling mode from progress through the stream
            if (bytes_taken < STREAM_BYTES / 3)
            begin
                send_idle_pct  <= 13;
                recv_stall_pct <= 47;
            end
            else if (bytes_taken < 2 * STREAM_BYTES / 3)
            begin
                send_idle_pct  <= 47;
                recv_stall_pct <= 13;
            end
            else
            begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end

            // Hold a stalled beat, otherwise offer the next one
            if (!(rx_ch.valid && !rx_ch.ready))
            begin
                go = (byte_backlog.size() != 0);
                if (go && byte_backlog[0].drain_first && frames_owed != 0)
                begin
                    go = 1'b0;
                end
                if (go && $urandom_range(99) < send_idle_pct)
                begin
                    go = 1'b0;
                end
                rx_ch.valid <= go;
                if (go)
                begin
                    rx_ch.rx_byte <= byte_backlog[0].value;
                end
            end
        end
    end

    // Frame monitor
    always @(posedge clk)
    begin
        frame_t want;
        byte_t  seen [PAYLOAD_SLOTS];
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                seen[0] = frame_ch.payload_0;
                seen[1] = frame_ch.payload_1;
                seen[2] = frame_ch.payload_2;
                seen[3] = frame_ch.payload_3;
                seen[4] = frame_ch.payload_4;
                seen[5] = frame_ch.payload_5;
                seen[6] = frame_ch.payload_6;
                seen[7] = frame_ch.payload_7;
                if (frames_due.size() == 0)
                begin
                    $error("frame id %h with no frame due", frame_ch.frame_id);
                    faults++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame_ch.frame_id !== want.id)
                    begin
                        $error("frame_id: expected %h, got %h", want.id, frame_ch.frame_id);
                        faults++;
                    end
                    if (frame_ch.frame_length !== want.len)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.len, frame_ch.frame_length);
                        faults++;
                    end
                    for (int k = 0; k < PAYLOAD_SLOTS; k++)
                    begin
                        if (seen[k] !== want.payload[k])
                        begin
                            $error("payload_%0d: expected %h, got %h",
                                   k, want.payload[k], seen[k]);
                            faults++;
                        end
                    end
                end
            end
            frame_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on stalled traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        byte_t fill [$];
        int    pick;
        int    n;
        frames_owed    = 0;
        bytes_taken    = 0;
        faults         = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 13;
        recv_stall_pct = 47;
        shadow_phase   = PH_ID_HIGH;
        shadow_id      = '0;
        shadow_len     = '0;
        shadow_count   = '0;
        for (int k = 0; k < PAYLOAD_SLOTS; k++)
        begin
            shadow_payload[k] = '0;
        end
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        frame_ch.ready = 1'b0;

        // Directed: zero length, full payload with a length far above the clamp,
        // then short frames that must hide the stale bytes
        fill = {};
        add_frame(16'h0000, 8'h00, fill, 1'b0);
        fill = {8'hff, 8'h00, 8'hff, 8'h00, 8'h80, 8'h7f, 8'h01, 8'hfe};
        add_frame(16'hffff, 8'hff, fill, 1'b0);
        fill = {8'h5a};
        add_frame(16'ha55a, 8'h01, fill, 1'b1);
        fill = {8'hc3, 8'h3c};
        add_frame(16'h0100, 8'h02, fill, 1'b0);

        // Random: mostly frames, a little noise that shifts the framing
        fill = {};
        while (byte_backlog.size() < STREAM_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                begin
                    add_beat(byte_t'($urandom), 1'b0);
                end
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    n = $urandom_range(0, LEN_CLAMP);
                end
                else if (pick < 85)
                begin
                    n = $urandom_range(LEN_CLAMP + 1, 15);
                end
                else
                begin
                    n = $urandom_range(16, 255);
                end
                add_frame(frame_id_t'($urandom), byte_t'(n), fill,
                          ($urandom_range(19) == 0));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain the stream, then let the pipeline settle
        do
        begin
            @(posedge clk);
        end
        while (byte_backlog.size() != 0 || frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (faults == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
design/cfd_pkg.sv
design/cfd_channels.sv
design/byte_stream_can_frame_deframer_core.sv
tb/byte_stream_can_frame_deframer_core_test.sv
